// ----- design/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define AFU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define AFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/afu_pkg.sv -----
package afu_pkg;

  // function_select codes
  localparam logic [2:0] FN_SIGMOID       = 3'd0;
  localparam logic [2:0] FN_TANH          = 3'd1;
  localparam logic [2:0] FN_RELU          = 3'd2;
  localparam logic [2:0] FN_SIGMOID_DERIV = 3'd3;
  localparam logic [2:0] FN_TANH_DERIV    = 3'd4;
  localparam logic [2:0] FN_RELU_DERIV    = 3'd5;

  // 1.0 and ln2 in unsigned q31
  localparam logic [31:0] Q31_ONE = 32'h8000_0000;
  localparam logic [30:0] LN2_Q31 = 31'd1488522236;

  // per-beat sideband that rides along the exp and divide stages
  typedef struct packed {
    logic [2:0]  mode;
    logic        neg;
    logic [15:0] res;
  } sb_t;

  function automatic logic [15:0] sat16(input logic signed [63:0] x);
    logic [15:0] y;
    if (x > 64'sd32767) begin
      y = 16'h7fff;
    end else if (x < -64'sd32768) begin
      y = 16'h8000;
    end else begin
      y = x[15:0];
    end
    return y;
  endfunction

endpackage

// ----- design/afu_exp_pipe.sv -----
module afu_exp_pipe #(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [47-FRAC_BITS:0] in_t,
  input  afu_pkg::sb_t         in_sb,
  output logic                 out_vld,
  output logic [31:0]          out_e,
  output afu_pkg::sb_t         out_sb
);
  import afu_pkg::*;

  localparam int TW = 48 - FRAC_BITS;
  localparam int KW = (TW > 31) ? TW - 30 : 1;
  localparam int CW = ((TW > 31) ? TW : 31) + 1;
  localparam int SW = 34;
  localparam int NT = 16;

  // range reduction t = k*ln2 + r, one quotient bit per stage
  logic          kd_vld [KW];
  logic [CW-1:0] kd_rem [KW];
  logic [KW-1:0] kd_k   [KW];
  sb_t           kd_sb  [KW];

  for (genvar i = 0; i < KW; i++) begin : g_kdiv
    localparam int B = KW - 1 - i;
    localparam logic [CW-1:0] DIV_SH = CW'({33'd0, LN2_Q31} << B);
    logic          p_vld;
    logic [CW-1:0] p_rem;
    logic [KW-1:0] p_k;
    sb_t           p_sb;

    if (i == 0) begin : g_first
      assign p_vld = in_vld;
      assign p_rem = CW'(in_t);
      assign p_k   = '0;
      assign p_sb  = in_sb;
    end else begin : g_next
      assign p_vld = kd_vld[i-1];
      assign p_rem = kd_rem[i-1];
      assign p_k   = kd_k[i-1];
      assign p_sb  = kd_sb[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        kd_vld[i] <= 1'b0;
      end else if (en) begin
        kd_vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (p_rem >= DIV_SH) begin
          kd_rem[i] <= p_rem - DIV_SH;
          kd_k[i]   <= p_k | (KW'(1) << B);
        end else begin
          kd_rem[i] <= p_rem;
          kd_k[i]   <= p_k;
        end
        kd_sb[i] <= p_sb;
      end
    end
  end

  // taylor series of exp(-r): each term is multiply, reciprocal multiply, correct
  logic                 a_vld [1:NT];
  logic [31:0]          a_x   [1:NT];
  logic [30:0]          a_r   [1:NT];
  logic signed [SW-1:0] a_sum [1:NT];
  logic [KW-1:0]        a_k   [1:NT];
  sb_t                  a_sb  [1:NT];

  logic                 b_vld [1:NT];
  logic [31:0]          b_x   [1:NT];
  logic [31:0]          b_q0  [1:NT];
  logic [30:0]          b_r   [1:NT];
  logic signed [SW-1:0] b_sum [1:NT];
  logic [KW-1:0]        b_k   [1:NT];
  sb_t                  b_sb  [1:NT];

  logic                 c_vld  [1:NT];
  logic [31:0]          c_term [1:NT];
  logic [30:0]          c_r    [1:NT];
  logic signed [SW-1:0] c_sum  [1:NT];
  logic [KW-1:0]        c_k    [1:NT];
  sb_t                  c_sb   [1:NT];

  for (genvar n = 1; n <= NT; n++) begin : g_term
    localparam logic [31:0] RCP  = 32'(64'hFFFF_FFFF / n);
    localparam logic [4:0]  DIVN = 5'(n);
    localparam bit          ODD  = (n % 2) == 1;
    logic                 p_vld;
    logic [31:0]          p_term;
    logic [30:0]          p_r;
    logic signed [SW-1:0] p_sum;
    logic [KW-1:0]        p_k;
    sb_t                  p_sb;
    logic [62:0]          prod_a;
    logic [63:0]          prod_b;
    logic [36:0]          rem_c;
    logic [31:0]          term_c;
    logic signed [SW-1:0] term_s;

    if (n == 1) begin : g_first
      assign p_vld  = kd_vld[KW-1];
      assign p_term = Q31_ONE;
      assign p_r    = kd_rem[KW-1][30:0];
      assign p_sum  = SW'(Q31_ONE);
      assign p_k    = kd_k[KW-1];
      assign p_sb   = kd_sb[KW-1];
    end else begin : g_next
      assign p_vld  = c_vld[n-1];
      assign p_term = c_term[n-1];
      assign p_r    = c_r[n-1];
      assign p_sum  = c_sum[n-1];
      assign p_k    = c_k[n-1];
      assign p_sb   = c_sb[n-1];
    end

    assign prod_a = 63'(p_term) * 63'(p_r);
    assign prod_b = 64'(a_x[n]) * 64'(RCP);
    // q0 is the true quotient or one short of it
    assign rem_c  = 37'(b_x[n]) - 37'(b_q0[n]) * 37'(DIVN);
    assign term_c = b_q0[n] + 32'(rem_c >= 37'(DIVN));
    assign term_s = $signed({2'b00, term_c});

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld[n] <= 1'b0;
        b_vld[n] <= 1'b0;
        c_vld[n] <= 1'b0;
      end else if (en) begin
        a_vld[n] <= p_vld;
        b_vld[n] <= a_vld[n];
        c_vld[n] <= b_vld[n];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_x[n]   <= prod_a[62:31];
        a_r[n]   <= p_r;
        a_sum[n] <= p_sum;
        a_k[n]   <= p_k;
        a_sb[n]  <= p_sb;

        b_x[n]   <= a_x[n];
        b_q0[n]  <= prod_b[63:32];
        b_r[n]   <= a_r[n];
        b_sum[n] <= a_sum[n];
        b_k[n]   <= a_k[n];
        b_sb[n]  <= a_sb[n];

        c_term[n] <= term_c;
        c_r[n]    <= b_r[n];
        c_sum[n]  <= ODD ? b_sum[n] - term_s : b_sum[n] + term_s;
        c_k[n]    <= b_k[n];
        c_sb[n]   <= b_sb[n];
      end
    end
  end

  // scale by 2^-k, anything past 31 bits of shift is zero
  logic [31:0] k_ext;
  logic [31:0] sum_u;

  assign k_ext = 32'(c_k[NT]);
  assign sum_u = c_sum[NT][31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= c_vld[NT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_e  <= (k_ext >= 32) ? '0 : sum_u >> k_ext[4:0];
      out_sb <= c_sb[NT];
    end
  end

endmodule

// ----- design/afu_div_pipe.sv -----
module afu_div_pipe #(
  parameter int FRAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [31:0]         in_e,
  input  afu_pkg::sb_t        in_sb,
  output logic                out_vld,
  output logic [FRAC_BITS:0]  out_q,
  output afu_pkg::sb_t        out_sb
);
  import afu_pkg::*;

  localparam int QW = FRAC_BITS + 1;
  localparam int DW = FRAC_BITS + 34;

  // numerator and denominator of the rounded quotient
  logic [31:0]   num;
  logic [32:0]   den;
  logic [DW-1:0] dvd;

  always_comb begin
    if (in_sb.mode == FN_TANH) begin
      num = Q31_ONE - in_e;
    end else begin
      num = in_sb.neg ? in_e : Q31_ONE;
    end
    den = 33'(Q31_ONE) + 33'(in_e);
    dvd = (DW'(num) << FRAC_BITS) + DW'(den >> 1);
  end

  logic          s_vld;
  logic [DW-1:0] s_rem;
  logic [32:0]   s_den;
  sb_t           s_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else if (en) begin
      s_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_rem <= dvd;
      s_den <= den;
      s_sb  <= in_sb;
    end
  end

  // restoring divide, one quotient bit per stage, msb first
  logic          dv_vld [QW];
  logic [DW-1:0] dv_rem [QW];
  logic [32:0]   dv_den [QW];
  logic [QW-1:0] dv_q   [QW];
  sb_t           dv_sb  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int B = FRAC_BITS - j;
    logic          p_vld;
    logic [DW-1:0] p_rem;
    logic [32:0]   p_den;
    logic [QW-1:0] p_q;
    sb_t           p_sb;
    logic [DW-1:0] den_sh;

    if (j == 0) begin : g_first
      assign p_vld = s_vld;
      assign p_rem = s_rem;
      assign p_den = s_den;
      assign p_q   = '0;
      assign p_sb  = s_sb;
    end else begin : g_next
      assign p_vld = dv_vld[j-1];
      assign p_rem = dv_rem[j-1];
      assign p_den = dv_den[j-1];
      assign p_q   = dv_q[j-1];
      assign p_sb  = dv_sb[j-1];
    end

    assign den_sh = DW'(p_den) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else if (en) begin
        dv_vld[j] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (p_rem >= den_sh) begin
          dv_rem[j] <= p_rem - den_sh;
          dv_q[j]   <= p_q | (QW'(1) << B);
        end else begin
          dv_rem[j] <= p_rem;
          dv_q[j]   <= p_q;
        end
        dv_den[j] <= p_den;
        dv_sb[j]  <= p_sb;
      end
    end
  end

  assign out_vld = dv_vld[QW-1];
  assign out_q   = dv_q[QW-1];
  assign out_sb  = dv_sb[QW-1];

endmodule

// ----- design/activation_function_unit.sv -----
// Elementwise activation unit: one signed fixed-point value in, one result out, with
// FRAC_BITS fractional bits (Q4.12 by default). function_select picks sigmoid, tanh,
// relu, or the derivatives a*(1-a), 1-a^2 and the step on a>0, where a is the already
// activated value; codes 6 and 7 give 0. Sigmoid and tanh are computed through exp(-t)
// in q31 (range reduction by ln2, a 16-term series, then a rounded divide) and land
// within one lsb of the true function. Every result saturates to 16 bits. A new beat
// is taken every clock while result is not held by result_ready low. Besides its input,
// setup and output registers, the pipe has three stages per term of the series (term
// multiply, reciprocal multiply, remainder fix), plus one stage per quotient bit of the
// ln2 reduction, KW = max(1, 18 - FRAC_BITS) bits wide, and of the final divide. The
// whole pipe advances together: when result is held by result_ready low, value_ready
// drops in the same cycle. Write function_select only while no beat is in flight.
`include "assert_macros.svh"

module activation_function_unit #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata,
  input  logic               value_valid,
  output logic               value_ready,
  input  logic signed [15:0] value,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [15:0] result
);
  import afu_pkg::*;

  localparam int TW = 48 - FRAC_BITS;                          // width of the exp argument
  localparam int BW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;  // width of 1.0 - a
  localparam int PW = 16 + BW;                                 // derivative product
  localparam int RW = ((PW > 2 * FRAC_BITS + 2) ? PW : 2 * FRAC_BITS + 2) + 1;
  localparam int QW = FRAC_BITS + 1;

  localparam logic signed [BW-1:0] ONE_B  = BW'(64'd1 << FRAC_BITS);
  localparam logic signed [RW-1:0] ONE_R  = RW'(64'd1 << FRAC_BITS);
  localparam logic signed [RW-1:0] ONE_SQ = RW'(64'd1 << (2 * FRAC_BITS));
  localparam logic signed [RW-1:0] HALF_R = RW'(64'd1 << (FRAC_BITS - 1));

  // config register
  logic [2:0] function_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      function_select <= FN_SIGMOID;
    end else if (cfg_we) begin
      function_select <= cfg_wdata;
    end
  end

  // one enable moves every stage; the output register is the last stage
  logic en;

  assign en          = !result_valid || result_ready;
  assign value_ready = en;

  // stage 1: magnitude, exp argument, and the derivative product
  logic [15:0]          mag;
  logic [TW-1:0]        t_arg;
  logic signed [BW-1:0] mul_b;

  always_comb begin
    mag   = value[15] ? 16'(-value) : 16'(value);
    // tanh works on exp(-2|x|), hence one more bit of shift
    t_arg = (function_select == FN_TANH) ? TW'(mag) << (32 - FRAC_BITS)
                                         : TW'(mag) << (31 - FRAC_BITS);
    mul_b = (function_select == FN_SIGMOID_DERIV) ? ONE_B - BW'(value) : BW'(value);
  end

  logic                 s1_vld;
  logic [2:0]           s1_mode;
  logic signed [15:0]   s1_v;
  logic [TW-1:0]        s1_t;
  logic signed [PW-1:0] s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= value_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode <= function_select;
      s1_v    <= value;
      s1_t    <= t_arg;
      s1_prod <= PW'(value) * PW'(mul_b);
    end
  end

  // stage 2: the modes that need no exp get their final value here
  logic signed [RW-1:0] d_sig;
  logic signed [RW-1:0] d_tanh;
  logic [15:0]          simple_res;

  always_comb begin
    // round to nearest, ties up: floor((p + half) / 2^frac)
    d_sig  = (RW'(s1_prod) + HALF_R) >>> FRAC_BITS;
    d_tanh = (ONE_SQ - RW'(s1_prod) + HALF_R) >>> FRAC_BITS;
    case (s1_mode)
      FN_RELU:          simple_res = (s1_v > 16'sd0) ? s1_v : '0;
      FN_SIGMOID_DERIV: simple_res = sat16(64'(d_sig));
      FN_TANH_DERIV:    simple_res = sat16(64'(d_tanh));
      FN_RELU_DERIV:    simple_res = (s1_v > 16'sd0) ? sat16(64'(ONE_R)) : '0;
      default:          simple_res = '0;
    endcase
  end

  logic          s2_vld;
  logic [TW-1:0] s2_t;
  sb_t           s2_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_t        <= s1_t;
      s2_sb.mode  <= s1_mode;
      s2_sb.neg   <= s1_v[15];
      s2_sb.res   <= simple_res;
    end
  end

  // exp(-t) in q31
  logic        exp_vld;
  logic [31:0] exp_e;
  sb_t         exp_sb;

  afu_exp_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_exp (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s2_vld),
    .in_t   (s2_t),
    .in_sb  (s2_sb),
    .out_vld(exp_vld),
    .out_e  (exp_e),
    .out_sb (exp_sb)
  );

  // rounded quotient for sigmoid and tanh
  logic          div_vld;
  logic [QW-1:0] div_q;
  sb_t           div_sb;

  afu_div_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (exp_vld),
    .in_e   (exp_e),
    .in_sb  (exp_sb),
    .out_vld(div_vld),
    .out_q  (div_q),
    .out_sb (div_sb)
  );

  // final select and saturation
  logic signed [QW:0] q_pos;
  logic signed [QW:0] q_tanh;
  logic [15:0]        res_fin;

  always_comb begin
    q_pos  = $signed({1'b0, div_q});
    // tanh is odd: negate the magnitude for negative inputs
    q_tanh = div_sb.neg ? -q_pos : q_pos;
    case (div_sb.mode)
      FN_SIGMOID: res_fin = sat16(64'(q_pos));
      FN_TANH:    res_fin = sat16(64'(q_tanh));
      default:    res_fin = div_sb.res;
    endcase
  end

  logic [2:0] out_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result   <= res_fin;
      out_mode <= div_sb.mode;
    end
  end

  // a held result freezes the pipe, so no beat may enter
  `AFU_ASSERT_IMPL(a_stall_blocks_input, result_valid && !result_ready, !value_ready,
                   "input accepted while result is held")
  // an accepted beat shows up in the first stage
  `AFU_ASSERT_NEXT(a_accept_enters, value_valid && value_ready, s1_vld,
                   "accepted beat missing from first stage")
  // a frozen first stage keeps its beat
  `AFU_ASSERT_NEXT(a_stage_holds, s1_vld && !en, s1_vld,
                   "first stage lost a beat during stall")
  // sigmoid, relu and the step never go negative
  `AFU_ASSERT_IMPL(a_nonneg_result,
                   result_valid && (out_mode == FN_SIGMOID || out_mode == FN_RELU ||
                                    out_mode == FN_RELU_DERIV),
                   !result[15], "negative result from a nonnegative function")

endmodule

// ----- test/afu_result_checker.sv -----
module afu_result_checker #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata,
  input  logic               value_valid,
  input  logic               value_ready,
  input  logic signed [15:0] value,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic signed [15:0] result,
  output int                 fail_count,
  output int                 in_flight
);
  import afu_pkg::*;

  localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic [2:0]         fn_sel;
  logic signed [15:0] predicted_q[$];

  // exp(-t) in unsigned q31: ln2 range reduction, then a truncated 16-term series
  function automatic logic [63:0] exp_neg_q31(input logic [63:0] t);
    logic [63:0]        k;
    logic [63:0]        r;
    logic [63:0]        term;
    logic signed [63:0] acc;
    k    = t / LN2_Q31;
    r    = t - k * LN2_Q31;
    acc  = Q31_ONE;
    term = Q31_ONE;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * r) >> 31) / n;
      if (n % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (k >= 63) return '0;
    return 64'(acc) >> k;
  endfunction

  // round(num * 2^FRAC_BITS / den) to nearest
  function automatic logic [63:0] q31_div_round(input logic [63:0] num, input logic [63:0] den);
    return ((num << FRAC_BITS) + (den >> 1)) / den;
  endfunction

  function automatic logic signed [15:0] activation(input logic [2:0] fn,
                                                    input logic signed [15:0] x);
    logic signed [63:0] v;
    logic signed [63:0] res;
    logic [63:0]        mag;
    logic [63:0]        e;
    logic [63:0]        num;
    logic [63:0]        den;
    v   = x;
    mag = (v < 0) ? -v : v;
    case (fn)
      FN_SIGMOID: begin
        e   = exp_neg_q31(mag << (31 - FRAC_BITS));
        num = (v >= 0) ? 64'(Q31_ONE) : e;
        den = 64'(Q31_ONE) + e;
        res = q31_div_round(num, den);
      end
      FN_TANH: begin
        e   = exp_neg_q31(mag << (32 - FRAC_BITS));
        num = 64'(Q31_ONE) - e;
        den = 64'(Q31_ONE) + e;
        res = q31_div_round(num, den);
        if (v < 0) res = -res;
      end
      FN_RELU:          res = (v > 0) ? v : 64'sd0;
      FN_SIGMOID_DERIV: res = (v * (ONE - v) + HALF) >>> FRAC_BITS;
      FN_TANH_DERIV:    res = ((ONE <<< FRAC_BITS) - v * v + HALF) >>> FRAC_BITS;
      FN_RELU_DERIV:    res = (v > 0) ? ONE : 64'sd0;
      default:          res = 64'sd0;
    endcase
    if (res > 64'sd32767) return 16'sh7fff;
    if (res < -64'sd32768) return 16'sh8000;
    return res[15:0];
  endfunction

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (rst) begin
      fn_sel = FN_SIGMOID;
      predicted_q.delete();
      fail_count = 0;
      in_flight <= 0;
    end else begin
      if (value_valid && value_ready) predicted_q.push_back(activation(fn_sel, value));
      if (result_valid && result_ready) begin
        if (predicted_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat, expected none, actual %0d", $time, result);
        end else begin
          want = predicted_q.pop_front();
          if (result !== want) begin
            fail_count++;
            $display("%0t: result mismatch, expected %0d, actual %0d", $time, want, result);
          end
        end
      end
      if (cfg_we) fn_sel = cfg_wdata;
      in_flight <= predicted_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
  import afu_pkg::*;

  localparam int FRAC_BITS = 12;
  // selector codes with no function behind them, the block returns 0
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;

  // every selector code, sigmoid in the low bits
  localparam logic [23:0] ALL_FNS = {FN_SPARE_HI, FN_SPARE_LO, FN_RELU_DERIV, FN_TANH_DERIV,
                                     FN_SIGMOID_DERIV, FN_RELU, FN_TANH, FN_SIGMOID};
  // one interesting mid-range value per selector, same order as above
  localparam logic [127:0] DIRECTED_MIDS = {-16'sd1, 16'sd1, 16'sd0, -16'sd4096,
                                            16'sd4096, 16'sd1, -16'sd1, 16'sd0};
  // order of the random blocks, block 0 in the low bits
  localparam int RANDOM_BLOCKS = 10;
  localparam logic [29:0] RANDOM_FNS = {FN_TANH, FN_SIGMOID_DERIV, FN_SPARE_LO, FN_RELU,
                                        FN_TANH_DERIV, FN_SPARE_HI, FN_SIGMOID_DERIV,
                                        FN_RELU_DERIV, FN_SIGMOID, FN_TANH};
  localparam int BLOCK_BEATS = 180;
  localparam int CALM_BEATS = 100;
  // receiver hold well past the pipe depth so the input side backs up
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_LIMIT = 2000;
  localparam int TIMEOUT_TIME = 6_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_wdata = FN_SIGMOID;
  logic               value_valid = 1'b0;
  logic               value_ready;
  logic signed [15:0] value = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [15:0] result;

  int fail_count;
  int in_flight;

  // set by the stimulus, read by the receiver process
  bit in_random = 1'b0;
  bit calm = 1'b0;
  int gap_pct = 0;

  activation_function_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  // predicts every accepted beat and compares results in order
  afu_result_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) result_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .value_valid (value_valid),
    .value_ready (value_ready),
    .value       (value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .fail_count  (fail_count),
    .in_flight   (in_flight)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the pipe hangs
  initial begin
    #(TIMEOUT_TIME);
    $display("CHECKS FAILED");
    $finish;
  end

  // mix of full-range, activated-range, near-rail and small values
  function automatic logic signed [15:0] pick_value();
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return r;
      1:       return 16'($urandom_range(0, 8192)) - 16'd4096;
      2:       return r[15] ? 16'h8000 + 16'(r[3:0]) : 16'h7fff - 16'(r[3:0]);
      default: return 16'($signed(r[11:0]));
    endcase
  endfunction

  // offer one beat, maybe after an idle burst, and return on the edge it is taken
  task automatic send_value(input logic signed [15:0] x);
    if (!calm && ($urandom % 100) < gap_pct) begin
      value_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    value_valid <= 1'b1;
    value <= x;
    @(posedge clk);
    while (!value_ready) @(posedge clk);
  endtask

  // drain the pipe completely, then write the selector
  task automatic set_function(input logic [2:0] fn);
    value_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= fn;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver: stall rate is redrawn at the start of each span, one long hold when the random part starts
  initial begin
    int  stall_pct;
    int  span;
    bit  long_hold_done;
    stall_pct = 0;
    span = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span = 64;
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 6;
          default: stall_pct = 30;
        endcase
      end
      span--;
      if (!long_hold_done && in_random) begin
        // sender keeps offering, so the pipe fills and value_ready drops
        long_hold_done = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        result_ready <= 1'b1;
      end else if (!calm && ($urandom % 100) < stall_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int guard;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: both rails and one mid value through every selector code, 6 and 7 included
    gap_pct = 10;
    for (int f = 0; f < 8; f++) begin
      set_function(ALL_FNS[3*f +: 3]);
      send_value(16'sh8000);
      send_value(16'sh7fff);
      send_value(DIRECTED_MIDS[16*f +: 16]);
    end

    // random blocks, one selector each, the pipe drains between them
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      set_function(RANDOM_FNS[3*b +: 3]);
      in_random = 1'b1;
      for (int i = 0; i < BLOCK_BEATS; i++) begin
        if (i % 60 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 5;
            default: gap_pct = 25;
          endcase
        end
        send_value(pick_value());
      end
    end

    // closing stretch at full rate on both sides
    calm = 1'b1;
    set_function(FN_SIGMOID);
    for (int i = 0; i < CALM_BEATS; i++) send_value(pick_value());
    value_valid <= 1'b0;

    // wait for the last results, then watch a while longer for strays
    guard = 0;
    @(posedge clk);
    while (in_flight != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);

    if (fail_count == 0 && in_flight == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/afu_pkg.sv
design/afu_exp_pipe.sv
design/afu_div_pipe.sv
design/activation_function_unit.sv
test/afu_result_checker.sv
test/tb_top.sv
